>>> rtl/core/boruvka_phase_union_find_top_assert.svh
// assertion macros for the boruvka phase union-find block
// no dependencies
`ifndef BORUVKA_PHASE_UNION_FIND_TOP_ASSERT_SVH
`define BORUVKA_PHASE_UNION_FIND_TOP_ASSERT_SVH

// same-cycle implication
`define BPUF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpuf check failed");

// next-cycle implication
`define BPUF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpuf check failed");

`endif

>>> rtl/core/bpuf_pkg.sv
// shared types and constants for the boruvka phase union-find block
// no dependencies
package bpuf_pkg;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_PHASE = 1'b1;

    localparam int RANK_BITS = 3;
    typedef logic [RANK_BITS-1:0] t_rank;
    localparam t_rank RANK_MAX = t_rank'(7);

    typedef enum logic [1:0] {
        CALL_P1_LO,
        CALL_P1_HI,
        CALL_P2_LO,
        CALL_P2_HI
    } t_call;

endpackage

>>> rtl/core/boruvka_phase_union_find_top.sv
// boruvka phase engine with an edge table and a union-find forest
// depends on bpuf_pkg and boruvka_phase_union_find_top_assert.svh
//
//  channel | handshake           | word
//  --------+---------------------+-------------------------------------------
//  input   | start && !busy      | kind, vertex_a, vertex_b, weight, edge_slot
//  result  | o_valid, one cycle  | chosen_slot, found, last
//
// add edge: records the slot if it is free and sets up both endpoints (ignored
// when invalid); phase: scans every slot, walking the roots of each live one
// with path compression, then every vertex, walking and uniting for each picked one.
// the walks through the parent memory (one read a cycle) set the phase time.
// synchronous reset clears valid bits and control; memories keep contents.
// results come out one at a time, never on back-to-back cycles.
// the receiver cannot stall; the final result has o_last set.
module boruvka_phase_union_find_top #(
    parameter int VERTEX_COUNT = 64,
    parameter int EDGE_SLOTS   = 256,
    parameter int WEIGHT_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [5:0]  i_vertex_a,
    input  logic [5:0]  i_vertex_b,
    input  logic [31:0] i_weight,
    input  logic [7:0]  i_edge_slot,
    output logic        o_valid,
    output logic [7:0]  o_chosen_slot,
    output logic        o_found,
    output logic        o_last
);
    import bpuf_pkg::*;

    localparam int VW = $clog2(VERTEX_COUNT);
    localparam int SW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_ADD_B, S_P1_SLOT, S_P1_EDGE, S_F_WALK, S_F_COMP, S_RET,
        S_P1_CA, S_P1_CB, S_P1_NEXT, S_P2_VERT, S_P2_CH, S_P2_EDGE,
        S_P2_RKA, S_P2_RKB, S_P2_NEXT, S_FIN
    } t_state;

    t_state r_state;
    t_call  r_ret;

    logic [VW-1:0]          mem_lo   [EDGE_SLOTS];
    logic [VW-1:0]          mem_hi   [EDGE_SLOTS];
    logic [WEIGHT_BITS-1:0] mem_cost [EDGE_SLOTS];
    logic [VW-1:0]          mem_par  [VERTEX_COUNT];
    t_rank                  mem_rank [VERTEX_COUNT];
    logic [SW-1:0]          mem_chs  [VERTEX_COUNT];
    logic [WEIGHT_BITS-1:0] mem_chc  [VERTEX_COUNT];

    logic [EDGE_SLOTS-1:0]   r_live;
    logic [VERTEX_COUNT-1:0] r_rkv;
    logic [VERTEX_COUNT-1:0] r_pkv;

    logic [VW-1:0]          r_q_lo, r_q_hi, r_q_par;
    logic [WEIGHT_BITS-1:0] r_q_cost, r_q_chc;
    logic [SW-1:0]          r_q_chs;
    t_rank                  r_q_rank;

    logic [SW-1:0]          r_s, r_e, r_pend_slot;
    logic [VW-1:0]          r_v, r_fv, r_fr, r_fx, r_ra, r_rb, r_hi;
    logic [WEIGHT_BITS-1:0] r_cost;
    t_rank                  r_ka;
    logic                   r_pend;

    logic                   in_ok;
    logic [VW-1:0]          va, vb;
    logic [SW-1:0]          slot_in;
    logic [WEIGHT_BITS-1:0] w_in;
    t_rank                  kb;

    assign va      = VW'(i_vertex_a);
    assign vb      = VW'(i_vertex_b);
    assign slot_in = SW'(i_edge_slot);
    assign w_in    = WEIGHT_BITS'(i_weight);
    assign in_ok   = (w_in != '0) && (32'(i_vertex_a) < VERTEX_COUNT)
                   && (32'(i_vertex_b) < VERTEX_COUNT) && (32'(i_edge_slot) < EDGE_SLOTS);
    assign kb      = r_rkv[r_rb] ? r_q_rank : '0;
    assign busy    = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= CALL_P1_LO;
            r_live  <= '0;
            r_rkv   <= '0;
            r_pkv   <= '0;
            r_pend  <= 1'b0;
            o_valid <= 1'b0;
            o_found <= 1'b0;
            o_last  <= 1'b0;
            o_chosen_slot <= '0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_kind == KIND_ADD) begin
                            if (in_ok) begin
                                if (!r_live[slot_in]) begin
                                    r_live[slot_in]   <= 1'b1;
                                    mem_lo[slot_in]   <= (va < vb) ? va : vb;
                                    mem_hi[slot_in]   <= (va < vb) ? vb : va;
                                    mem_cost[slot_in] <= w_in;
                                end
                                mem_par[va] <= va;
                                if (!r_rkv[va]) begin
                                    r_rkv[va]    <= 1'b1;
                                    mem_rank[va] <= '0;
                                end
                                r_fv    <= vb;
                                r_state <= S_ADD_B;
                            end
                        end else begin
                            r_pkv   <= '0;
                            r_pend  <= 1'b0;
                            r_s     <= '0;
                            r_state <= S_P1_SLOT;
                        end
                    end
                end
                S_ADD_B: begin
                    mem_par[r_fv] <= r_fv;
                    if (!r_rkv[r_fv]) begin
                        r_rkv[r_fv]    <= 1'b1;
                        mem_rank[r_fv] <= '0;
                    end
                    r_state <= S_IDLE;
                end
                S_P1_SLOT: begin
                    if (r_live[r_s]) begin
                        r_q_lo   <= mem_lo[r_s];
                        r_q_hi   <= mem_hi[r_s];
                        r_q_cost <= mem_cost[r_s];
                        r_state  <= S_P1_EDGE;
                    end else begin
                        r_state <= S_P1_NEXT;
                    end
                end
                S_P1_EDGE: begin
                    r_hi    <= r_q_hi;
                    r_cost  <= r_q_cost;
                    r_fv    <= r_q_lo;
                    r_fr    <= r_q_lo;
                    r_q_par <= mem_par[r_q_lo];
                    r_ret   <= CALL_P1_LO;
                    r_state <= S_F_WALK;
                end
                // root walk, then path compression
                S_F_WALK: begin
                    if (r_q_par == r_fr) begin
                        r_fx <= r_fv;
                        if (r_fv == r_fr) begin
                            r_state <= S_RET;
                        end else begin
                            r_q_par <= mem_par[r_fv];
                            r_state <= S_F_COMP;
                        end
                    end else begin
                        r_fr    <= r_q_par;
                        r_q_par <= mem_par[r_q_par];
                    end
                end
                S_F_COMP: begin
                    mem_par[r_fx] <= r_fr;
                    if (r_q_par == r_fr) begin
                        r_state <= S_RET;
                    end else begin
                        r_fx    <= r_q_par;
                        r_q_par <= mem_par[r_q_par];
                    end
                end
                S_RET: begin
                    unique case (r_ret) inside
                        CALL_P1_LO, CALL_P2_LO: begin
                            r_ra    <= r_fr;
                            r_fv    <= r_hi;
                            r_fr    <= r_hi;
                            r_q_par <= mem_par[r_hi];
                            r_ret   <= (r_ret == CALL_P1_LO) ? CALL_P1_HI : CALL_P2_HI;
                            r_state <= S_F_WALK;
                        end
                        CALL_P1_HI: begin
                            r_rb <= r_fr;
                            if (r_ra == r_fr) begin
                                r_state <= S_P1_NEXT;
                            end else begin
                                r_q_chs <= mem_chs[r_ra];
                                r_q_chc <= mem_chc[r_ra];
                                r_state <= S_P1_CA;
                            end
                        end
                        CALL_P2_HI: begin
                            r_rb        <= r_fr;
                            r_live[r_e] <= 1'b0;
                            if (r_ra == r_fr) begin
                                r_state <= S_P2_NEXT;
                            end else begin
                                r_q_rank <= mem_rank[r_ra];
                                r_state  <= S_P2_RKA;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_P1_CA: begin
                    if (!r_pkv[r_ra] || (r_cost < r_q_chc)) begin
                        r_pkv[r_ra]   <= 1'b1;
                        mem_chs[r_ra] <= r_s;
                        mem_chc[r_ra] <= r_cost;
                    end
                    r_q_chs <= mem_chs[r_rb];
                    r_q_chc <= mem_chc[r_rb];
                    r_state <= S_P1_CB;
                end
                S_P1_CB: begin
                    if (!r_pkv[r_rb] || (r_cost < r_q_chc)) begin
                        r_pkv[r_rb]   <= 1'b1;
                        mem_chs[r_rb] <= r_s;
                        mem_chc[r_rb] <= r_cost;
                    end
                    r_state <= S_P1_NEXT;
                end
                S_P1_NEXT: begin
                    if (r_s == SW'(EDGE_SLOTS - 1)) begin
                        r_v     <= '0;
                        r_state <= S_P2_VERT;
                    end else begin
                        r_s     <= r_s + 1'b1;
                        r_state <= S_P1_SLOT;
                    end
                end
                S_P2_VERT: begin
                    if (r_pkv[r_v]) begin
                        r_q_chs <= mem_chs[r_v];
                        r_state <= S_P2_CH;
                    end else begin
                        r_state <= S_P2_NEXT;
                    end
                end
                S_P2_CH: begin
                    r_e <= r_q_chs;
                    if (r_live[r_q_chs]) begin
                        r_q_lo  <= mem_lo[r_q_chs];
                        r_q_hi  <= mem_hi[r_q_chs];
                        r_state <= S_P2_EDGE;
                    end else begin
                        r_state <= S_P2_NEXT;
                    end
                end
                S_P2_EDGE: begin
                    r_hi    <= r_q_hi;
                    r_fv    <= r_q_lo;
                    r_fr    <= r_q_lo;
                    r_q_par <= mem_par[r_q_lo];
                    r_ret   <= CALL_P2_LO;
                    r_state <= S_F_WALK;
                end
                S_P2_RKA: begin
                    r_ka     <= r_rkv[r_ra] ? r_q_rank : '0;
                    r_q_rank <= mem_rank[r_rb];
                    r_state  <= S_P2_RKB;
                end
                // union by rank, then hold the word until the next one shows
                S_P2_RKB: begin
                    if (r_ka > kb) begin
                        mem_par[r_rb] <= r_ra;
                        r_rkv[r_rb]   <= 1'b0;
                    end else begin
                        mem_par[r_ra] <= r_rb;
                        r_rkv[r_ra]   <= 1'b0;
                        if (r_ka == kb) begin
                            r_rkv[r_rb]    <= 1'b1;
                            mem_rank[r_rb] <= (kb < RANK_MAX) ? kb + 1'b1 : RANK_MAX;
                        end
                    end
                    if (r_pend) begin
                        o_valid       <= 1'b1;
                        o_found       <= 1'b1;
                        o_last        <= 1'b0;
                        o_chosen_slot <= 8'(r_pend_slot);
                    end
                    r_pend      <= 1'b1;
                    r_pend_slot <= r_e;
                    r_state     <= S_P2_NEXT;
                end
                S_P2_NEXT: begin
                    if (r_v == VW'(VERTEX_COUNT - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_v     <= r_v + 1'b1;
                        r_state <= S_P2_VERT;
                    end
                end
                S_FIN: begin
                    o_valid       <= 1'b1;
                    o_found       <= r_pend;
                    o_last        <= 1'b1;
                    o_chosen_slot <= r_pend ? 8'(r_pend_slot) : '0;
                    r_pend        <= 1'b0;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "boruvka_phase_union_find_top_assert.svh"

    `BPUF_ASSERT_NOW(a_notfound_last, i_clk, i_rst_n, o_valid && !o_found, o_last)
    `BPUF_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_valid && o_last, !busy)
    `BPUF_ASSERT_NEXT(a_word_gap, i_clk, i_rst_n, o_valid, !o_valid)

endmodule
